>>> src/ovle_pkg.sv
// Shared types and codes for the ordered value list engine.
package ovle_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        OP_PREPEND   = 3'd0,
        OP_APPEND    = 3'd1,
        OP_INSERT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_ALL   = 3'd4,
        OP_FIND      = 3'd5,
        OP_READ      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // Broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic cmp_en;   // compare phase: build each cell's mark
        logic upd_en;   // update phase: shift or write along the chain
        op_t  op;
        logic full;     // list is at capacity
    } cell_ctl_t;

endpackage

>>> src/ovle_cell.sv
// One list slot: holds an entry and its mark, compares and shifts with its neighbors.
module ovle_cell import ovle_pkg::*; #(
    parameter int IDX   = 0,
    parameter int OCC_W = 5
) (
    input  logic               aclk,
    input  cell_ctl_t          ctl,
    input  logic [OCC_W-1:0]   occ,
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] left_entry,
    input  logic [VALUE_W-1:0] right_entry,
    input  logic               right_mark,
    input  logic               pfx_in,
    output logic [VALUE_W-1:0] entry,
    output logic               mark,
    output logic               pfx_out,
    output logic               extra
);

    logic [VALUE_W-1:0] entry_reg, entry_next;
    logic               mark_reg, mark_next;
    logic               match, greater, in_rng, at_end;

    assign match   = (entry_reg == value);
    assign greater = ($signed(entry_reg) > $signed(value));
    assign in_rng  = (OCC_W'(IDX) < occ);
    assign at_end  = (OCC_W'(IDX) == occ);

    always_comb begin
        entry_next = entry_reg;
        mark_next  = mark_reg;
        if (ctl.cmp_en) begin
            unique case (ctl.op)
                OP_PREPEND:   mark_next = !ctl.full && (IDX == 0);
                OP_APPEND:    mark_next = !ctl.full && at_end;
                OP_INSERT:    mark_next = !ctl.full && ((greater && in_rng) || at_end);
                OP_DEL_FIRST,
                OP_DEL_ALL,
                OP_FIND:      mark_next = match && in_rng;
                default:      mark_next = 1'b0;
            endcase
        end else if (ctl.upd_en) begin
            unique case (ctl.op)
                OP_PREPEND,
                OP_APPEND,
                OP_INSERT: begin
                    // open a slot: everything past the insert point moves right
                    if (pfx_in) begin
                        entry_next = left_entry;
                    end else if (mark_reg) begin
                        entry_next = value;
                    end
                end
                OP_DEL_FIRST,
                OP_DEL_ALL: begin
                    // close the first marked slot: pull from the right
                    if (pfx_in || mark_reg) begin
                        entry_next = right_entry;
                        mark_next  = right_mark;
                    end
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        mark_reg  <= mark_next;
    end

    assign entry   = entry_reg;
    assign mark    = mark_reg;
    assign pfx_out = pfx_in || mark_reg;
    assign extra   = pfx_in && mark_reg;

endmodule

>>> src/ordered_value_list_engine_top.sv
// Top level of the ordered value list engine: request sequencer and cell chain.
//
// Usage: a request enters on the s_ stream (operation, value, position) and
// exactly one result leaves on the m_ stream (status, found, count, read_value).
// The list lives in a chain of CAPACITY cells; each cell compares its entry
// with the request value in parallel, and a prefix flag ripples along the
// chain to pick the insert or delete point, so all cells shift together.
// Sequence: a request passes a compare phase and then an update phase; the
// result is loaded when the update phase ends. Delete-all removes one match
// per update cycle until none is left.
// Overlap: the next request is accepted in the update cycle that finishes the
// current one; during delete-all it waits until the last match is removed.
// Reset (aresetn low at a clock edge) empties the list and drops any pending
// result; entry storage itself is not cleared.
// Stall: the result sits in an output register. A new request is taken while
// it waits, but the compare phase holds until that register is free.
module ordered_value_list_engine_top import ovle_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] operation, [34:3] value, [38:35] position, [39] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [2] found, [7:3] count, [39:8] read_value
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = (OCC_W > 5) ? OCC_W : 5;
    localparam int PW    = (IDX_W > 4) ? IDX_W : 4;
    localparam int CMPW  = (OCC_W > 4) ? OCC_W : 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched request
    op_t                op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [3:0]         pos_reg;

    logic [OCC_W-1:0]   occ_reg, occ_next;

    // result register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] ent_w  [CAPACITY];
    logic [CAPACITY-1:0] mark_w;
    logic [CAPACITY-1:0] extra_w;
    logic [CAPACITY:0]   pfx_w;

    logic               accept, full, any_mark, more, finish;
    logic               rd_ok, found;
    status_t            status;
    logic [VALUE_W-1:0] rd_value;
    logic [PW-1:0]      pos_w;
    logic [IDX_W-1:0]   pos_idx;
    logic [CW-1:0]      count_w;

    assign full     = (occ_reg >= OCC_W'(CAPACITY));
    assign any_mark = pfx_w[CAPACITY];
    assign more     = |extra_w;
    assign finish   = (op_reg != OP_DEL_ALL) || !more;

    assign ctl.cmp_en = (state_reg == S_CMP);
    assign ctl.upd_en = (state_reg == S_UPD);
    assign ctl.op     = op_reg;
    assign ctl.full   = full;

    // ---------------- cell chain ----------------
    assign pfx_w[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_e, right_e;
        logic               right_m;

        if (i == 0) begin : g_first
            assign left_e = value_reg;
        end else begin : g_mid
            assign left_e = ent_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
            assign right_m = 1'b0;
        end else begin : g_inner
            assign right_e = ent_w[i+1];
            assign right_m = mark_w[i+1];
        end

        ovle_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occ         (occ_reg),
            .value       (value_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_mark  (right_m),
            .pfx_in      (pfx_w[i]),
            .entry       (ent_w[i]),
            .mark        (mark_w[i]),
            .pfx_out     (pfx_w[i+1]),
            .extra       (extra_w[i])
        );
    end

    // ---------------- read port ----------------
    assign pos_w   = PW'(pos_reg);
    assign pos_idx = pos_w[IDX_W-1:0];
    assign rd_ok   = (CMPW'(pos_reg) < CMPW'(occ_reg));

    // ---------------- result and occupancy ----------------
    always_comb begin
        occ_next = occ_reg;
        status   = ST_OK;
        found    = 1'b0;
        rd_value = '0;
        unique case (op_reg)
            OP_PREPEND,
            OP_APPEND,
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    occ_next = occ_reg + 1'b1;
                end
            end
            OP_DEL_FIRST,
            OP_DEL_ALL: begin
                if (any_mark) begin
                    occ_next = occ_reg - 1'b1;
                end else begin
                    status = ST_MISSING;
                end
            end
            OP_FIND: begin
                found = any_mark;
                if (!any_mark) begin
                    status = ST_MISSING;
                end
            end
            OP_READ: begin
                if (rd_ok) begin
                    rd_value = ent_w[pos_idx];
                end else begin
                    status = ST_MISSING;
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
    end

    assign count_w = CW'(occ_next);

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_UPD) && finish);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                // hold until the result register can take this request's result
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (finish) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rd_value, count_w[4:0], found, status};
                    state_next    = s_tvalid ? S_CMP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == S_UPD) begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            op_reg    <= op_t'(s_tdata[2:0]);
            value_reg <= s_tdata[34:3];
            pos_reg   <= s_tdata[38:35];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_accept_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_CMP))
        else $error("accepted request did not enter compare");

    a_result_from_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_UPD))
        else $error("result loaded outside update phase");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_UPD) && !full &&
         (op_reg == OP_PREPEND || op_reg == OP_APPEND || op_reg == OP_INSERT))
        |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("insert did not grow the list");
`endif

endmodule
